// File: rtl/dfa_string_recognizer_macros.svh
// Assertion macros for the DFA recognizer checker.
// Each macro assumes signals named clk and arst_n in the calling scope.
`ifndef DFA_STRING_RECOGNIZER_MACROS_SVH
`define DFA_STRING_RECOGNIZER_MACROS_SVH

// Same-cycle implication.
`define DSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dsr_pkg.sv
`timescale 1ns / 1ps

package dsr_pkg;

	localparam int STATE_W    = 4;
	localparam int SYMBOL_W   = 8;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 8;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_FEED  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_STATE = 1'b0,
		REG_ACCEPT_MASK = 1'b1
	} cfg_reg_t;

	// One table entry: defined flag over next state.
	typedef struct packed {
		logic               defined;
		logic [STATE_W-1:0] next;
	} entry_t;

	// One result item, accepted in bit 0.
	typedef struct packed {
		logic bad_symbol;
		logic accepted;
	} result_t;

endpackage

// File: rtl/dfa_string_recognizer.sv
`timescale 1ns / 1ps

// Table-driven DFA recognizer. Transitions live in a single-port synchronous
// RAM of STATE_COUNT << SYMBOL_BITS entries ({state, symbol} addressed); a
// write item (tuser = write) loads one entry, feed items step one symbol
// through the table, and the feed item carrying tlast returns one result
// (accepted, bad_symbol). A query item returns the accept bit of the start
// state right away. Rate: one item per cycle in steady state while the result
// queue has room, writes, feeds and queries mixed freely; each result passes
// through stage 1 into the result queue, whose count raises m_tvalid.
// The loop that sets this rate is the RAM read:
// the entry read for one symbol resolves in the next cycle and feeds the
// address of the following symbol's read combinationally. After reset the
// block sweeps all STATE_COUNT << SYMBOL_BITS entries (4096 by default) to
// undefined, one entry per cycle, with s_tready low; config writes are
// taken throughout. Config may change only while the block is idle.
module dfa_string_recognizer #(
	parameter int STATE_COUNT = 16,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_we,
	input  logic [dsr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsr_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [dsr_pkg::S_TDATA_W-1:0]     s_tdata,  // symbol[7:0], source_state[11:8], next_state[15:12]
	input  logic [dsr_pkg::OP_W-1:0]          s_tuser,  // operation[1:0]
	input  logic                              s_tlast,  // last
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [dsr_pkg::M_TDATA_W-1:0]     m_tdata   // accepted[0], bad_symbol[1], zero pad
);

	import dsr_pkg::*;

	localparam int SB           = $clog2(STATE_COUNT);
	localparam int SYMBOL_COUNT = 1 << SYMBOL_BITS;
	localparam int DEPTH        = STATE_COUNT * SYMBOL_COUNT;
	localparam int ADDR_W       = SB + SYMBOL_BITS;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [8:0] STATE_LIMIT  = 9'(STATE_COUNT);
	localparam logic [8:0] SYMBOL_LIMIT = 9'(SYMBOL_COUNT);
	localparam int FIFO_DEPTH = 3;

	// ------------------------------------------------------------------
	// Input unpacking
	// ------------------------------------------------------------------
	op_t                 in_op;
	logic [SYMBOL_W-1:0] in_sym;
	logic [STATE_W-1:0]  in_src;
	logic [STATE_W-1:0]  in_nxt;
	logic                accept;

	assign in_op  = op_t'(s_tuser);
	assign in_sym = s_tdata[7:0];
	assign in_src = s_tdata[11:8];
	assign in_nxt = s_tdata[15:12];
	assign accept = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Config registers
	// ------------------------------------------------------------------
	logic [STATE_W-1:0]    start_q;
	logic [CFG_DATA_W-1:0] mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			mask_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_STATE: start_q <= cfg_data[STATE_W-1:0];
				REG_ACCEPT_MASK: mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Post-reset clear sweep
	// ------------------------------------------------------------------
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) clr_busy_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Walk state: committed copy plus the lookup in flight in stage 1
	// ------------------------------------------------------------------
	logic               str_start_q;   // next fed symbol opens a string
	logic [STATE_W-1:0] state_q;
	logic               rej_q;

	logic               feed_s1;
	logic               query_s1;
	logic               lookup_s1;     // RAM data in rd_s1 is meaningful
	logic               rej_s1;
	logic [STATE_W-1:0] state_s1;
	logic               last_s1;
	logic               qacc_s1;
	entry_t             rd_s1;

	logic [STATE_W-1:0] state_now;
	logic               rej_now;

	// Resolve the stage-1 lookup.
	always_comb begin
		state_now = state_s1;
		rej_now   = rej_s1;
		if (lookup_s1) begin
			if (rd_s1.defined) state_now = rd_s1.next;
			else               rej_now   = 1'b1;
		end
	end

	// Effective state seen by the item now at the input (bypass from s1).
	logic [STATE_W-1:0] eff_state;
	logic               eff_rej;
	logic [STATE_W-1:0] base_state;
	logic               base_rej;
	logic [7:0]         base_state8;
	logic [7:0]         src8;
	logic               sym_ok;
	logic               rej_pre;
	logic               write_ok;

	assign eff_state   = feed_s1 ? state_now : state_q;
	assign eff_rej     = feed_s1 ? rej_now   : rej_q;
	assign base_state  = str_start_q ? start_q : eff_state;
	assign base_rej    = str_start_q ? 1'b0    : eff_rej;
	assign base_state8 = 8'(base_state);
	assign src8        = 8'(in_src);
	assign sym_ok      = 9'(in_sym) < SYMBOL_LIMIT;
	assign rej_pre     = base_rej || !(9'(base_state) < STATE_LIMIT) || !sym_ok;
	assign write_ok    = (9'(in_src) < STATE_LIMIT) && (9'(in_nxt) < STATE_LIMIT) && sym_ok;

	// ------------------------------------------------------------------
	// Transition RAM, single port: sweep, item write or item read
	// ------------------------------------------------------------------
	entry_t            mem [DEPTH];
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	entry_t            mem_wdata;

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = clr_addr_q;
		mem_wdata = '0;
		if (clr_busy_q) begin
			mem_we = 1'b1;
		end else if (accept) begin
			unique case (in_op)
				OP_WRITE: begin
					mem_we    = write_ok;
					mem_addr  = {src8[SB-1:0], in_sym[SYMBOL_BITS-1:0]};
					mem_wdata = '{defined: 1'b1, next: in_nxt};
				end
				OP_FEED: begin
					mem_re   = !rej_pre;
					mem_addr = {base_state8[SB-1:0], in_sym[SYMBOL_BITS-1:0]};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rd_s1 <= mem[mem_addr];
	end

	// ------------------------------------------------------------------
	// Stage 1 and walk-state registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_s1     <= 1'b0;
			query_s1    <= 1'b0;
			str_start_q <= 1'b1;
			state_q     <= '0;
			rej_q       <= 1'b0;
		end else begin
			feed_s1  <= accept && (in_op == OP_FEED);
			query_s1 <= accept && (in_op == OP_QUERY);
			if (feed_s1) begin
				state_q <= state_now;
				rej_q   <= rej_now;
			end
			if (accept && (in_op == OP_FEED)) str_start_q <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lookup_s1 <= !rej_pre;
			rej_s1    <= rej_pre;
			state_s1  <= base_state;
			last_s1   <= s_tlast;
			qacc_s1   <= mask_q[start_q];
		end
	end

	// ------------------------------------------------------------------
	// Result FIFO: three entries decouple m_tready from s_tready
	// ------------------------------------------------------------------
	logic    res_valid_s1;
	result_t res_s1;

	assign res_valid_s1 = (feed_s1 && last_s1) || query_s1;

	always_comb begin
		if (query_s1) begin
			res_s1 = '{bad_symbol: 1'b0, accepted: qacc_s1};
		end else begin
			res_s1 = '{bad_symbol: rej_now, accepted: !rej_now && mask_q[state_now]};
		end
	end

	result_t    fifo_q [FIFO_DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = M_TDATA_W'(fifo_q[rd_ptr_q]);
	// Room for every result still in flight, counted before this cycle's pop.
	assign s_tready = !clr_busy_q && ((3'(cnt_q) + 3'(res_valid_s1)) <= 3'd2);

	always_ff @(posedge clk) begin
		if (res_valid_s1) fifo_q[wr_ptr_q] <= res_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_valid_s1)
				wr_ptr_q <= (wr_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + 2'(res_valid_s1) - 2'(pop);
		end
	end

endmodule

// File: rtl/dsr_checker.sv
`timescale 1ns / 1ps

`include "dfa_string_recognizer_macros.svh"

module dsr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// handshake rules
	`DSR_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`DSR_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

	// a string with bad_symbol set is never reported as accepted
	`DSR_ASSERT_NOW(a_excl, m_tvalid, !(m_tdata[0] && m_tdata[1]), "accepted and bad_symbol both set")
	// pad bits stay zero
	`DSR_ASSERT_NOW(a_pad, m_tvalid, m_tdata[7:2] == 6'd0, "nonzero pad in result")
	// a result on an empty output traces back to an accepted input item
	`DSR_ASSERT_NOW(a_origin, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result with no item")

endmodule

bind dfa_string_recognizer dsr_checker u_dsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

// Testbench for dfa_string_recognizer.
// Items go in through a blocking send task and are scored by one monitor
// process. The monitor runs the transition table, the walk state and the
// register copies alongside the block and queues the verdict each
// string-ending feed or empty-string query should produce.
// Results are compared in order.
module tb;

	import dsr_pkg::*;

	localparam int          LIMIT     = 1_000_000; // sweep + ~2.4k items at worst gap/stall
	localparam int          MAX_LINES = 40;
	localparam logic [1:0]  OP_UNUSED = 2'd3;      // ignored opcode
	localparam int          PHASES    = 5;
	localparam int          PER_PHASE = 390;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // symbol[7:0], source_state[11:8], next_state[15:12]
	logic [OP_W-1:0]       s_tuser;   // operation[1:0]
	logic                  s_tlast;   // last
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // accepted[0], bad_symbol[1], zero pad

	// predictor state
	bit                    tbl_defined [0:4095];
	logic [STATE_W-1:0]    tbl_next    [0:4095];
	logic [STATE_W-1:0]    walk_state;
	bit                    walk_rejected;
	bit                    walk_at_start;
	logic [STATE_W-1:0]    start_reg;
	logic [15:0]           mask_reg;
	result_t               pending_verdicts [$];

	int                    error_count;
	int                    cycles;
	bit                    smooth;    // no gaps and no stalls while set
	int                    rx_hold;   // long receiver hold-off, counted down per cycle
	int                    rx_stall;
	int                    rx_roll;

	// current alphabet of the random automaton
	logic [SYMBOL_W-1:0]   alpha [0:7];
	int                    alpha_size;

	dfa_string_recognizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run-length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_LINES)
			$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// Append one verdict at the tail of the expected-result queue.
	function automatic void add_verdict(input result_t verdict);
		pending_verdicts.insert(pending_verdicts.size(), verdict);
	endfunction

	// One item through the predictor; same ordering rules as the block.
	function automatic void step_recognizer(input logic [1:0] op, input logic [7:0] sym,
			input logic [3:0] src, input logic [3:0] nxt, input logic last);
		result_t verdict;
		case (op)
			OP_WRITE: begin
				tbl_defined[{src, sym}] = 1'b1;
				tbl_next[{src, sym}]    = nxt;
			end
			OP_QUERY: begin
				verdict.accepted   = mask_reg[start_reg];
				verdict.bad_symbol = 1'b0;
				add_verdict(verdict);
			end
			OP_FEED: begin
				if (walk_at_start) begin
					// start state is latched on the first symbol only
					walk_state    = start_reg;
					walk_rejected = 1'b0;
				end
				if (!walk_rejected) begin
					if (tbl_defined[{walk_state, sym}])
						walk_state = tbl_next[{walk_state, sym}];
					else
						walk_rejected = 1'b1; // undefined transition, sticks to end of string
				end
				walk_at_start = last;
				if (last) begin
					verdict.accepted   = !walk_rejected && mask_reg[walk_state];
					verdict.bad_symbol = walk_rejected;
					add_verdict(verdict);
				end
			end
			default: ; // unused opcode: no result, no state change
		endcase
	endfunction

	// Predict on input handshakes, score on output handshakes.
	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				step_recognizer(s_tuser, s_tdata[7:0], s_tdata[11:8], s_tdata[15:12], s_tlast);
			if (m_tvalid && m_tready) begin
				got = m_tdata[1:0];
				if (pending_verdicts.size() == 0) begin
					report_mismatch($sformatf("unexpected result %b", m_tdata));
				end else begin
					want = pending_verdicts.pop_front();
					if (got.accepted !== want.accepted)
						report_mismatch($sformatf("accepted %b, want %b",
							got.accepted, want.accepted));
					if (got.bad_symbol !== want.bad_symbol)
						report_mismatch($sformatf("bad_symbol %b, want %b",
							got.bad_symbol, want.bad_symbol));
					if (m_tdata[7:2] !== '0)
						report_mismatch($sformatf("pad bits %b not zero", m_tdata[7:2]));
				end
			end
		end
	end

	// Receiver: mostly ready, short stalls, a few long ones, plus the hold-off.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_tready = 1'b0;
			rx_hold--;
		end else if (smooth) begin
			m_tready = 1'b1;
		end else if (rx_stall > 0) begin
			m_tready = 1'b0;
			rx_stall--;
		end else begin
			rx_roll = $urandom_range(99);
			if (rx_roll < 70) begin
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b0;
				rx_stall = (rx_roll < 96) ? $urandom_range(0, 3) : $urandom_range(15, 50);
			end
		end
	end

	function automatic int sender_gap();
		int r;
		r = $urandom_range(99);
		if (smooth || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// Called and returns at a falling edge.
	task automatic send_item(input logic [1:0] op, input logic [7:0] sym,
			input logic [3:0] src, input logic [3:0] nxt, input logic last);
		int gap;
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {nxt, src, sym};
		s_tlast  = last;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		gap = sender_gap();
		repeat (gap) @(negedge clk);
	endtask

	task automatic feed(input logic [7:0] sym, input logic last);
		send_item(OP_FEED, sym, 4'($urandom), 4'($urandom), last);
	endtask

	task automatic load_transition(input logic [3:0] src, input logic [7:0] sym,
			input logic [3:0] nxt);
		send_item(OP_WRITE, sym, src, nxt, 1'($urandom_range(0, 1)));
	endtask

	task automatic query_empty();
		send_item(OP_QUERY, 8'($urandom), 4'($urandom), 4'($urandom),
			1'($urandom_range(0, 1)));
	endtask

	// Wait for every verdict, then for the pipeline to drain writes.
	task automatic settle();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_register(input cfg_reg_t idx, input logic [15:0] value);
		settle();
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_START_STATE: start_reg = value[3:0];
			REG_ACCEPT_MASK: mask_reg  = value;
			default: ;
		endcase
	endtask

	// Cleared table and reset registers: nothing accepts, every symbol is bad.
	task automatic test_reset_state();
		query_empty();
		feed(8'h00, 1'b1);
		feed(8'hFF, 1'b0);
		feed(8'h80, 1'b1);
	endtask

	// Extremes of states and symbols, every opcode, and the corner cases:
	// rewrite, write and query mid-string, reject absorbing later symbols.
	task automatic test_directed();
		set_register(REG_START_STATE, 16'hFFFF); // upper bits dropped -> 15
		set_register(REG_ACCEPT_MASK, 16'h8009);
		load_transition(4'd15, 8'hFF, 4'd0);
		load_transition(4'd0, 8'h00, 4'd15);
		query_empty();                                      // mask[15]
		feed(8'hFF, 1'b0);
		feed(8'h00, 1'b1);                                  // 15 -> 0 -> 15, accept
		send_item(OP_UNUSED, 8'hFF, 4'd15, 4'd15, 1'b1);    // ignored
		feed(8'hFF, 1'b0);                                  // now in 0
		query_empty();                                      // string keeps going
		load_transition(4'd0, 8'hAA, 4'd3);                 // usable at once
		feed(8'hAA, 1'b1);                                  // ends in 3, accept
		load_transition(4'd15, 8'hFF, 4'd5);                // replaces 15/FF
		feed(8'hFF, 1'b1);                                  // ends in 5, reject
		feed(8'h55, 1'b0);                                  // undefined: latch
		feed(8'hFF, 1'b0);                                  // absorbed
		feed(8'h00, 1'b1);                                  // bad_symbol
		feed(8'hFF, 1'b1);                                  // reject cleared by new string
		set_register(REG_START_STATE, 16'h0000);
		set_register(REG_ACCEPT_MASK, 16'hFFFF);
		feed(8'h00, 1'b1);                                  // 0 -> 15, accept
		query_empty();
	endtask

	function automatic logic [7:0] pick_symbol();
		if ($urandom_range(99) < 92)
			return alpha[3'($urandom_range(0, alpha_size - 1))];
		return 8'($urandom_range(0, 255));
	endfunction

	// Random automaton per phase, then strings mostly over its alphabet.
	task automatic test_random_automata();
		int n;
		int roll;
		int len;
		for (int ph = 0; ph < PHASES; ph++) begin
			smooth = (ph == 2);
			case (ph)
				0: set_register(REG_START_STATE, 16'h0000);
				1: set_register(REG_START_STATE, 16'h000F);
				default: set_register(REG_START_STATE, 16'($urandom_range(0, 65535)));
			endcase
			case (ph)
				3: set_register(REG_ACCEPT_MASK, 16'h0000);
				4: set_register(REG_ACCEPT_MASK, 16'hFFFF);
				default: set_register(REG_ACCEPT_MASK, 16'($urandom_range(0, 65535)));
			endcase
			alpha_size = $urandom_range(2, 8);
			for (int i = 0; i < alpha_size; i++)
				alpha[3'(i)] = 8'($urandom_range(0, 255));
			n = 0;
			for (int s = 0; s < 16; s++)
				for (int i = 0; i < alpha_size; i++)
					if ($urandom_range(9) != 0) begin
						load_transition(4'(s), alpha[3'(i)], 4'($urandom_range(0, 15)));
						n++;
					end
			while (n < PER_PHASE) begin
				roll = $urandom_range(99);
				if (roll < 80) begin
					len = ($urandom_range(19) == 0) ? $urandom_range(20, 40)
						: $urandom_range(1, 10);
					for (int k = 0; k < len; k++) begin
						// something else slipped into the middle of a string
						if (k != 0 && $urandom_range(19) == 0) begin
							case ($urandom_range(2))
								0: query_empty();
								1: load_transition(4'($urandom), pick_symbol(), 4'($urandom));
								default: send_item(OP_UNUSED, 8'($urandom), 4'($urandom),
									4'($urandom), 1'($urandom_range(0, 1)));
							endcase
							n++;
						end
						feed(pick_symbol(), k == len - 1);
						n++;
					end
				end else if (roll < 88) begin
					query_empty();
					n++;
				end else if (roll < 96) begin
					load_transition(4'($urandom), pick_symbol(), 4'($urandom));
					n++;
				end else begin
					send_item(OP_UNUSED, 8'($urandom), 4'($urandom), 4'($urandom),
						1'($urandom_range(0, 1)));
				end
			end
		end
		smooth = 1'b0;
	endtask

	// Receiver holds off long enough for the block to back up into s_tready,
	// then the sender waits for every result before a second burst.
	task automatic test_backpressure();
		settle();
		rx_hold = 300;
		for (int i = 0; i < 40; i++) begin
			if (i % 4 == 0)
				query_empty();
			else
				feed(pick_symbol(), 1'b1);
		end
		settle();
		for (int i = 0; i < 30; i++)
			feed(pick_symbol(), $urandom_range(0, 2) == 0);
		feed(pick_symbol(), 1'b1);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_START_STATE;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_WRITE;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		smooth    = 1'b0;
		rx_hold   = 0;
		rx_stall  = 0;
		error_count = 0;
		cycles    = 0;
		for (int i = 0; i < 4096; i++) begin
			tbl_defined[12'(i)] = 1'b0;
			tbl_next[12'(i)]    = '0;
		end
		walk_state    = '0;
		walk_rejected = 1'b0;
		walk_at_start = 1'b1;
		start_reg     = '0;
		mask_reg      = '0;
		alpha_size    = 1;
		alpha[0]      = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first item waits out the table clear on its own
		test_reset_state();
		test_directed();
		test_random_automata();
		test_backpressure();

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
